@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("Assertion failed: next-cycle implication.");

`endif

@@ sv/spp_pkg.sv @@
// Package with the types, codes and character constants of the format specifier parser.
`timescale 1ns / 1ps
`default_nettype none
package spp_pkg;

  localparam int unsigned ACC_W = 31;
  localparam int unsigned WIDE_W = ACC_W + 4;
  localparam logic [ACC_W-1:0] ACC_LIMIT = {ACC_W{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam int unsigned FLAG_W = 5;
  localparam int unsigned FB_MINUS = 0;
  localparam int unsigned FB_PLUS = 1;
  localparam int unsigned FB_BLANK = 2;
  localparam int unsigned FB_SHARP = 3;
  localparam int unsigned FB_ZERO = 4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_LC_C = 8'h63;
  localparam logic [7:0] CH_LC_S = 8'h73;
  localparam logic [7:0] CH_LC_P = 8'h70;
  localparam logic [7:0] CH_LC_D = 8'h64;
  localparam logic [7:0] CH_LC_I = 8'h69;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_LC_X = 8'h78;
  localparam logic [7:0] CH_UC_X = 8'h58;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  typedef enum logic [1:0] {
    PH_FLAGS = 2'd0,
    PH_WIDTH = 2'd1,
    PH_PREC  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WOVF = 2'd1,
    ST_POVF = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CONV_C   = 4'd0,
    CONV_S   = 4'd1,
    CONV_P   = 4'd2,
    CONV_D   = 4'd3,
    CONV_I   = 4'd4,
    CONV_U   = 4'd5,
    CONV_LX  = 4'd6,
    CONV_UX  = 4'd7,
    CONV_PCT = 4'd8
  } conv_e;

  typedef struct packed {
    logic              is_digit;
    logic [3:0]        digit;
    logic [FLAG_W-1:0] flag_mask;
    logic              is_dot;
    logic              is_conv;
    conv_e             conv;
  } spp_item_t;

endpackage
`default_nettype wire

@@ sv/spp_front.sv @@
// Front end: accepts characters and classifies them into decoded items for the queue.
`timescale 1ns / 1ps
`default_nettype none
module spp_front import spp_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output spp_item_t  item_o
);

  always_comb begin
    item_o = '0;
    item_o.is_digit = symbol_i inside {[CH_DIGIT0:CH_DIGIT9]};
    item_o.digit = symbol_i[3:0];
    item_o.is_dot = (symbol_i == CH_DOT);
    case (symbol_i)
      CH_MINUS:  item_o.flag_mask[FB_MINUS] = 1'b1;
      CH_PLUS:   item_o.flag_mask[FB_PLUS] = 1'b1;
      CH_BLANK:  item_o.flag_mask[FB_BLANK] = 1'b1;
      CH_SHARP:  item_o.flag_mask[FB_SHARP] = 1'b1;
      CH_DIGIT0: item_o.flag_mask[FB_ZERO] = 1'b1;
      default:   item_o.flag_mask = '0;
    endcase
    item_o.is_conv = 1'b1;
    case (symbol_i)
      CH_LC_C:    item_o.conv = CONV_C;
      CH_LC_S:    item_o.conv = CONV_S;
      CH_LC_P:    item_o.conv = CONV_P;
      CH_LC_D:    item_o.conv = CONV_D;
      CH_LC_I:    item_o.conv = CONV_I;
      CH_LC_U:    item_o.conv = CONV_U;
      CH_LC_X:    item_o.conv = CONV_LX;
      CH_UC_X:    item_o.conv = CONV_UX;
      CH_PERCENT: item_o.conv = CONV_PCT;
      default: begin
        item_o.conv = CONV_C;
        item_o.is_conv = 1'b0;
      end
    endcase
  end

  assign in_stall_o = queue_full_i;
  assign push_o = in_valid_i && !queue_full_i;

endmodule
`default_nettype wire

@@ sv/spp_queue.sv @@
// Small FIFO of decoded items between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module spp_queue import spp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  spp_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output spp_item_t head_item_o
);

  spp_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/spp_back.sv @@
// Back end: runs the parse state machine on decoded items and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module spp_back import spp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  spp_item_t         head_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FLAG_W-1:0] flag_bits_o,
  output logic [ACC_W-1:0]  field_width_o,
  output logic [ACC_W-1:0]  prec_value_o,
  output logic              prec_given_o,
  output logic [3:0]        conversion_o,
  output logic [1:0]        status_o
);

  phase_e             phase_q, phase_d;
  logic [FLAG_W-1:0]  flag_q, flag_d;
  logic [ACC_W-1:0]   width_q, width_d;
  logic [ACC_W-1:0]   prec_q, prec_d;
  logic               seen_q, seen_d;

  logic               out_valid_q, out_valid_d;
  logic [FLAG_W-1:0]  out_flag_q;
  logic [ACC_W-1:0]   out_width_q;
  logic [ACC_W-1:0]   out_prec_q;
  logic               out_given_q;
  conv_e              out_conv_q;
  status_e            out_status_q;

  logic [ACC_W-1:0]   acc_sel;
  logic [WIDE_W-1:0]  wide;
  logic               ovf;
  logic               flag_hit;
  logic               emit;
  logic               out_ready;
  status_e            res_status;
  conv_e              res_conv;

  always_comb begin
    phase_d = phase_q;
    flag_d = flag_q;
    width_d = width_q;
    prec_d = prec_q;
    seen_d = seen_q;
    emit = 1'b0;
    res_status = ST_OK;
    res_conv = CONV_C;

    acc_sel = (phase_q == PH_PREC) ? prec_q : width_q;
    wide = WIDE_W'({acc_sel, 3'b000}) + WIDE_W'({acc_sel, 1'b0})
         + WIDE_W'(head_item_i.digit);
    ovf = (wide >= WIDE_W'(ACC_LIMIT));
    flag_hit = (phase_q != PH_WIDTH) && (phase_q != PH_PREC)
            && (head_item_i.flag_mask != '0);

    if (phase_q == PH_PREC) begin
      if (head_item_i.is_digit) begin
        if (ovf) begin
          emit = 1'b1;
          res_status = ST_POVF;
        end else begin
          prec_d = wide[ACC_W-1:0];
          seen_d = 1'b1;
        end
      end else begin
        emit = 1'b1;
        res_status = head_item_i.is_conv ? ST_OK : ST_BAD;
        res_conv = head_item_i.conv;
      end
    end else if (flag_hit) begin
      flag_d = flag_q | head_item_i.flag_mask;
    end else if (head_item_i.is_digit) begin
      if (ovf) begin
        emit = 1'b1;
        res_status = ST_WOVF;
      end else begin
        width_d = wide[ACC_W-1:0];
        phase_d = PH_WIDTH;
      end
    end else if (head_item_i.is_dot) begin
      phase_d = PH_PREC;
    end else begin
      emit = 1'b1;
      res_status = head_item_i.is_conv ? ST_OK : ST_BAD;
      res_conv = head_item_i.conv;
    end

    if (emit) begin
      phase_d = PH_FLAGS;
      flag_d = '0;
      width_d = '0;
      prec_d = '0;
      seen_d = 1'b0;
    end

    out_ready = !out_valid_q || !out_stall_i;
    pop_o = head_valid_i && (!emit || out_ready);

    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAGS;
      flag_q <= '0;
      width_q <= '0;
      prec_q <= '0;
      seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        flag_q <= flag_d;
        width_q <= width_d;
        prec_q <= prec_d;
        seen_q <= seen_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_status_q <= res_status;
      if (res_status == ST_OK) begin
        out_flag_q <= flag_q;
        out_width_q <= width_q;
        out_prec_q <= seen_q ? prec_q : '0;
        out_given_q <= seen_q;
        out_conv_q <= res_conv;
      end else begin
        out_flag_q <= '0;
        out_width_q <= '0;
        out_prec_q <= '0;
        out_given_q <= 1'b0;
        out_conv_q <= CONV_C;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign flag_bits_o = out_flag_q;
  assign field_width_o = out_width_q;
  assign prec_value_o = out_prec_q;
  assign prec_given_o = out_given_q;
  assign conversion_o = out_conv_q;
  assign status_o = out_status_q;

endmodule
`default_nettype wire

@@ sv/printf_spec_parser.sv @@
// Top level of the printf format specifier parser: front end, item queue and back end.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   symbol_i
//   out      output     out_valid_o / out_stall_i flag_bits_o, field_width_o, prec_value_o,
//                                                 prec_given_o, conversion_o, status_o
//
// One character is taken per cycle unless the queue is full; the back end retires one
// item per cycle unless an ending item finds the result register stalled.
// The four-entry queue lets the front keep accepting while the result register is stalled.
// Reset clears the parse state, the queue and the result valid at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module printf_spec_parser import spp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        symbol_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FLAG_W-1:0] flag_bits_o,
  output logic [ACC_W-1:0]  field_width_o,
  output logic [ACC_W-1:0]  prec_value_o,
  output logic              prec_given_o,
  output logic [3:0]        conversion_o,
  output logic [1:0]        status_o
);

  logic      push;
  logic      queue_full;
  logic      pop;
  logic      head_valid;
  spp_item_t push_item;
  spp_item_t head_item;

  spp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .symbol_i     (symbol_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  spp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  spp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .flag_bits_o   (flag_bits_o),
    .field_width_o (field_width_o),
    .prec_value_o  (prec_value_o),
    .prec_given_o  (prec_given_o),
    .conversion_o  (conversion_o),
    .status_o      (status_o)
  );

endmodule
`default_nettype wire

@@ sv/printf_spec_parser_chk.sv @@
// Port-level checker for the format specifier parser and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module printf_spec_parser_chk import spp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [FLAG_W-1:0] flag_bits_o,
  input logic [ACC_W-1:0]  field_width_o,
  input logic [ACC_W-1:0]  prec_value_o,
  input logic              prec_given_o,
  input logic [3:0]        conversion_o,
  input logic [1:0]        status_o
);

  logic                      stalled;
  logic                      err_clear;
  logic                      below_limit;
  logic [FLAG_W+2*ACC_W+6:0] out_bits;

  assign stalled = out_valid_o && out_stall_i;
  assign err_clear = (flag_bits_o == '0) && (field_width_o == '0) && (prec_value_o == '0)
                  && !prec_given_o && (conversion_o == '0);
  assign below_limit = (field_width_o != ACC_LIMIT) && (prec_value_o != ACC_LIMIT);
  assign out_bits = {flag_bits_o, field_width_o, prec_value_o, prec_given_o, conversion_o,
                     status_o};

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_bits))

  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), err_clear)

  `ASSERT_IMPLIES(a_conv_range, clk_i, rst_ni, out_valid_o, conversion_o <= CONV_PCT)

  `ASSERT_IMPLIES(a_prec_absent, clk_i, rst_ni, out_valid_o && !prec_given_o, prec_value_o == '0)

  `ASSERT_IMPLIES(a_below_limit, clk_i, rst_ni, out_valid_o, below_limit)

endmodule

bind printf_spec_parser printf_spec_parser_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .flag_bits_o   (flag_bits_o),
  .field_width_o (field_width_o),
  .prec_value_o  (prec_value_o),
  .prec_given_o  (prec_given_o),
  .conversion_o  (conversion_o),
  .status_o      (status_o)
);
`default_nettype wire
